// ----- rtl/core/sdcm_pkg.sv -----
// ----------------------------------------------------------------------------
// sdcm_pkg
// Shared types and constants of the sleep duty-cycle monitor: event codes,
// timer constants and the interface of the iterative ratio unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcm_pkg;

    // Event codes carried by the operation field.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_SLEEP  = 2'd2;

    localparam int          TICK_MS        = 16;
    localparam int          TICK_SHIFT     = 4;      // log2 of TICK_MS
    localparam logic [15:0] DEBOUNCE_RESET = 16'd250;
    localparam logic [6:0]  DUTY_FULL      = 7'd100;

    // Multiplier operand of the ratio unit: wide enough for the duty scale of 100.
    localparam int MULT_WIDTH = 7;
    localparam int BIT_IDX_W  = $clog2(MULT_WIDTH);

    // Top multiplier bit walked for the duty percent.
    localparam logic [BIT_IDX_W-1:0] DUTY_TOP_BIT = BIT_IDX_W'(6);

    typedef struct packed {
        logic                  start;
        logic [BIT_IDX_W-1:0]  start_bit;
        logic [MULT_WIDTH-1:0] mult;
    } ratio_req_t;

    typedef struct packed {
        logic                  done;
        logic [MULT_WIDTH-1:0] quotient;
    } ratio_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sdcm_ratio_unit.sv -----
// ----------------------------------------------------------------------------
// sdcm_ratio_unit
// Iterative unit for floor(addend * mult / divisor) with addend < divisor.
// For each multiplier bit one shared modular add step runs twice:
// the remainder is doubled modulo the divisor, then the addend is added
// modulo the divisor when the bit is set. Carries form the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcm_ratio_unit
    import sdcm_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ratio_req_t            req,
    input  wire logic [TIME_WIDTH-1:0] addend,
    input  wire logic [TIME_WIDTH-1:0] divisor,
    output      ratio_stat_t           stat
);

    logic                  busy_reg;
    logic                  phase_reg;
    logic                  done_reg;
    logic [BIT_IDX_W-1:0]  bit_reg;
    logic [TIME_WIDTH-1:0] rem_reg;
    logic [TIME_WIDTH-1:0] addend_reg;
    logic [TIME_WIDTH-1:0] divisor_reg;
    logic [MULT_WIDTH-1:0] mult_reg;
    logic [MULT_WIDTH-1:0] quot_reg;

    logic [TIME_WIDTH-1:0] step_x;
    logic [TIME_WIDTH-1:0] step_gap;
    logic                  step_carry;
    logic [TIME_WIDTH-1:0] rem_next;

    // The shared step: rem + x modulo the divisor, with rem and x below it.
    always_comb
    begin
        if (phase_reg)
        begin
            step_x = mult_reg[bit_reg] ? addend_reg : '0;
        end
        else
        begin
            step_x = rem_reg;
        end
        step_gap   = divisor_reg - step_x;
        step_carry = (rem_reg >= step_gap);
        rem_next   = step_carry ? (rem_reg - step_gap) : (rem_reg + step_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                bit_reg   <= req.start_bit;
            end
            else if (busy_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    if (bit_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quot_reg    <= '0;
            mult_reg    <= req.mult;
            addend_reg  <= addend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            if (phase_reg)
            begin
                quot_reg <= quot_reg + MULT_WIDTH'(step_carry);
            end
            else
            begin
                quot_reg <= {quot_reg[MULT_WIDTH-2:0], step_carry};
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sleep_duty_cycle_monitor.sv -----
// ----------------------------------------------------------------------------
// sleep_duty_cycle_monitor
// Tracks time, slept time and a button debounce window from a stream of
// tick, button and sleep events, and reports the active duty cycle.
// ----------------------------------------------------------------------------
// Usage: an event item enters on in_valid/in_ready with operation and
// sub_count; exactly one result item leaves on out_valid/out_ready for each
// event. cfg_valid/cfg_ready writes debounce_ms (always ready); write it only
// while no event is in flight.
// Path: after acceptance an event passes ST_SUBDIV, ST_SLEEP_END, ST_EVAL
// and ST_OUT; a button report whose duty needs a divide also passes ST_DUTY
// after ST_EVAL. The sub-tick time comes from a reciprocal multiply, and the
// duty percent from the iterative ratio unit, which walks its seven multiplier bits.
// Flow: one event at a time; in_ready is high only while no event is
// in work, so a new event may enter while the last result still waits.
// A stalled receiver holds the result register, and the next event then
// waits in its final state until that register frees up.
// Reset: the tick counter and the sleep and debounce times clear, no sleep is
// pending, debounce is closed and debounce_ms returns to 250.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_duty_cycle_monitor
    import sdcm_pkg::*;
#(
    parameter int TIME_WIDTH    = 32,
    parameter int SUBTICK_STEPS = 250
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  sub_count,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        report_valid,
    output      logic [31:0] time_ms,
    output      logic [31:0] active_ms,
    output      logic [6:0]  duty_percent,
    output      logic        sleep_granted
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SUBDIV    = 6'b000010,
        ST_SLEEP_END = 6'b000100,
        ST_EVAL      = 6'b001000,
        ST_DUTY      = 6'b010000,
        ST_OUT       = 6'b100000
    } state_t;

    localparam logic [TIME_WIDTH-1:0] TICK_W = TIME_WIDTH'(TICK_MS);

    // The sub-tick time floor(sub_count * 16 / SUBTICK_STEPS) is taken by a
    // reciprocal multiply that is exact for every 12-bit product.
    localparam int SUB_PROD_W  = 8 + TICK_SHIFT;
    localparam int STEPS_LOG   = $clog2(SUBTICK_STEPS);
    localparam int RECIP_SHIFT = SUB_PROD_W + STEPS_LOG;
    localparam int RECIP_W     = SUB_PROD_W + 2;
    localparam int PROD_W      = RECIP_SHIFT + SUB_PROD_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) / SUBTICK_STEPS) + 64'd1);

    function automatic logic [31:0] to_port(input logic [TIME_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

    state_t                state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [7:0]            sub_reg, sub_next;
    logic [15:0]           debounce_ms_reg;
    logic [TIME_WIDTH-1:0] ms_counter_reg, ms_counter_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [TIME_WIDTH-1:0] sleep_start_reg, sleep_start_next;
    logic                  sleep_pending_reg, sleep_pending_next;
    logic [TIME_WIDTH-1:0] sleep_total_reg, sleep_total_next;
    logic [TIME_WIDTH-1:0] debounce_start_reg, debounce_start_next;
    logic                  debounce_active_reg, debounce_active_next;

    // Result being built for the current event.
    logic                  res_report_reg, res_report_next;
    logic                  res_grant_reg, res_grant_next;
    logic [TIME_WIDTH-1:0] res_active_reg, res_active_next;
    logic [6:0]            res_duty_reg, res_duty_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic                  report_valid_reg;
    logic [31:0]           time_ms_reg;
    logic [31:0]           active_ms_reg;
    logic [6:0]            duty_percent_reg;
    logic                  sleep_granted_reg;

    ratio_req_t            ratio_req;
    ratio_stat_t           ratio_stat;
    logic [TIME_WIDTH-1:0] ratio_addend;
    logic [TIME_WIDTH-1:0] ratio_divisor;

    logic [PROD_W-1:0]     sub_product;
    logic [SUB_PROD_W-1:0] sub_quotient;
    logic [TIME_WIDTH-1:0] active_now;
    logic [TIME_WIDTH-1:0] debounce_age;
    logic                  accept;

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign active_now   = now_reg - sleep_total_reg;
    assign debounce_age = now_reg - debounce_start_reg;
    assign sub_product  = PROD_W'({sub_reg, TICK_SHIFT'(0)}) * PROD_W'(RECIP);
    assign sub_quotient = sub_product[PROD_W-1:RECIP_SHIFT];

    always_comb
    begin
        state_next           = state_reg;
        op_next              = op_reg;
        sub_next             = sub_reg;
        ms_counter_next      = ms_counter_reg;
        now_next             = now_reg;
        sleep_start_next     = sleep_start_reg;
        sleep_pending_next   = sleep_pending_reg;
        sleep_total_next     = sleep_total_reg;
        debounce_start_next  = debounce_start_reg;
        debounce_active_next = debounce_active_reg;
        res_report_next      = res_report_reg;
        res_grant_next       = res_grant_reg;
        res_active_next      = res_active_reg;
        res_duty_next        = res_duty_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        out_load             = 1'b0;
        ratio_req.start      = 1'b0;
        ratio_req.start_bit  = DUTY_TOP_BIT;
        ratio_req.mult       = MULT_WIDTH'(DUTY_FULL);
        ratio_addend         = active_now;
        ratio_divisor        = now_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    sub_next        = sub_count;
                    res_report_next = 1'b0;
                    res_grant_next  = 1'b0;
                    res_active_next = '0;
                    res_duty_next   = '0;
                    if (operation == OP_TICK)
                    begin
                        ms_counter_next = ms_counter_reg + TICK_W;
                    end
                    state_next = ST_SUBDIV;
                end
            end
            ST_SUBDIV:
            begin
                now_next   = ms_counter_reg + TIME_WIDTH'(sub_quotient);
                state_next = ST_SLEEP_END;
            end
            ST_SLEEP_END:
            begin
                if (op_reg == OP_TICK || op_reg == OP_BUTTON)
                begin
                    if (sleep_pending_reg)
                    begin
                        sleep_total_next = sleep_total_reg + (now_reg - sleep_start_reg);
                    end
                    sleep_pending_next = 1'b0;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_OUT;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (debounce_active_reg &&
                            debounce_age > TIME_WIDTH'(debounce_ms_reg))
                        begin
                            debounce_active_next = 1'b0;
                        end
                    end
                    OP_BUTTON:
                    begin
                        if (!debounce_active_reg)
                        begin
                            res_report_next      = 1'b1;
                            res_active_next      = active_now;
                            debounce_start_next  = now_reg;
                            debounce_active_next = 1'b1;
                            if (now_reg == '0)
                            begin
                                res_duty_next = '0;
                            end
                            else if (active_now >= now_reg)
                            begin
                                res_duty_next = DUTY_FULL;
                            end
                            else
                            begin
                                ratio_req.start = 1'b1;
                                state_next      = ST_DUTY;
                            end
                        end
                    end
                    OP_SLEEP:
                    begin
                        if (!debounce_active_reg)
                        begin
                            res_grant_next = 1'b1;
                            if (!sleep_pending_reg)
                            begin
                                sleep_start_next   = now_reg;
                                sleep_pending_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // The unused code only reports the time.
                    end
                endcase
            end
            ST_DUTY:
            begin
                if (ratio_stat.done)
                begin
                    res_duty_next = ratio_stat.quotient[6:0];
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            debounce_ms_reg     <= DEBOUNCE_RESET;
            ms_counter_reg      <= '0;
            sleep_start_reg     <= '0;
            sleep_pending_reg   <= 1'b0;
            sleep_total_reg     <= '0;
            debounce_start_reg  <= '0;
            debounce_active_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            ms_counter_reg      <= ms_counter_next;
            sleep_start_reg     <= sleep_start_next;
            sleep_pending_reg   <= sleep_pending_next;
            sleep_total_reg     <= sleep_total_next;
            debounce_start_reg  <= debounce_start_next;
            debounce_active_reg <= debounce_active_next;
            out_valid_reg       <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                debounce_ms_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sub_reg        <= sub_next;
        now_reg        <= now_next;
        res_report_reg <= res_report_next;
        res_grant_reg  <= res_grant_next;
        res_active_reg <= res_active_next;
        res_duty_reg   <= res_duty_next;
        if (out_load)
        begin
            report_valid_reg  <= res_report_reg;
            time_ms_reg       <= to_port(now_reg);
            active_ms_reg     <= to_port(res_active_reg);
            duty_percent_reg  <= res_duty_reg;
            sleep_granted_reg <= res_grant_reg;
        end
    end

    sdcm_ratio_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ratio_req),
        .addend  (ratio_addend),
        .divisor (ratio_divisor),
        .stat    (ratio_stat)
    );

    assign out_valid     = out_valid_reg;
    assign report_valid  = report_valid_reg;
    assign time_ms       = time_ms_reg;
    assign active_ms     = active_ms_reg;
    assign duty_percent  = duty_percent_reg;
    assign sleep_granted = sleep_granted_reg;

    // A reported duty never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_percent <= DUTY_FULL)
        else $error("duty percent above 100");

    // A report and a sleep grant come from different events.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(report_valid && sleep_granted))
        else $error("report and sleep grant in one item");

    // Items without a report carry no active time and no duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !report_valid) |-> (active_ms == '0 && duty_percent == '0))
        else $error("active time or duty without a report");

    // A sleep only starts on a sleep request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sleep_pending_reg) |-> $past(op_reg) == OP_SLEEP)
        else $error("sleep started by an event other than a sleep request");

endmodule

`default_nettype wire
